// File: hdl/btfr_pkg.sv
// shared types and constants for the battery telemetry frame receiver
package btfr_pkg;

  // frame geometry
  localparam int DATA_BYTES = 10;
  localparam int POS_W      = 4;

  localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0] POS_CHECK = POS_W'(DATA_BYTES + 1);

  // elapsed millisecond counter, saturating
  localparam int              ELAPSED_W   = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_CRIT_TIMEOUT = CFG_ADDR_W'(1);

  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [15:0] CRIT_TIMEOUT_RST = 16'd1000;

  // input item kind
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } btfr_cmd_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [15:0]        cell_min_mv;
    logic [15:0]        cell_max_mv;
    logic signed [7:0]  pack_temp_c;
    logic [7:0]         charge_percent;
    logic signed [15:0] pack_current_ca;
    logic [15:0]        pack_voltage_cv;
    logic               link_ok;
    logic               checksum_bad;
    logic               frame_done;
  } btfr_result_t;

  localparam int RES_W       = $bits(btfr_result_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = 8;

endpackage

// File: hdl/battery_telemetry_frame_receiver.sv
// An accepted item's result is registered in the result register, or in the skid
// register if stalled. Throughput: one item per cycle while the skid is empty;
// the two-entry buffer lets input keep flowing for one item while out_tready is low.
// Reset: synchronous, active-low rst_n clears frame state, latched fields, elapsed
// count, link flag and the output buffer; start marker returns to 0xAA and the
// critical timeout to 1000 ms.
module battery_telemetry_frame_receiver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [btfr_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                           in_tuser,   // [0] cmd
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] frame_done, [1] checksum_bad, [2] link_ok, [18:3] pack_voltage_cv,
  // [34:19] pack_current_ca, [42:35] charge_percent, [50:43] pack_temp_c,
  // [66:51] cell_max_mv, [82:67] cell_min_mv, upper bits zero
  output logic [btfr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [btfr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [btfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import btfr_pkg::*;

  // configuration registers
  logic [7:0]  start_marker_r;
  logic [15:0] crit_timeout_r;

  // frame state
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic [7:0]           shadow_r   [DATA_BYTES];
  logic [7:0]           shadow_nxt [DATA_BYTES];
  logic [15:0]          volt_r, volt_nxt;
  logic [15:0]          curr_r, curr_nxt;
  logic [7:0]           charge_r, charge_nxt;
  logic [7:0]           temp_r, temp_nxt;
  logic [15:0]          cmax_r, cmax_nxt;
  logic [15:0]          cmin_r, cmin_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 link_r, link_nxt;

  // output buffer
  logic         out_valid_r, out_valid_nxt;
  btfr_result_t out_data_r, out_data_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  btfr_result_t skid_data_r, skid_data_nxt;

  btfr_result_t res;
  logic         in_fire;
  logic         out_fire;
  btfr_cmd_t    cmd;
  logic [7:0]   rx_byte;
  logic         done;
  logic         bad;

  assign cmd      = btfr_cmd_t'(in_tuser[0]);
  assign rx_byte  = in_tdata[7:0];
  assign in_tready = !skid_valid_r;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      crit_timeout_r <= CRIT_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_MARKER: start_marker_r <= cfg_wdata[7:0];
        REG_CRIT_TIMEOUT: crit_timeout_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // per-item state update and result
  always_comb begin
    pos_nxt     = pos_r;
    xor_nxt     = xor_r;
    shadow_nxt  = shadow_r;
    volt_nxt    = volt_r;
    curr_nxt    = curr_r;
    charge_nxt  = charge_r;
    temp_nxt    = temp_r;
    cmax_nxt    = cmax_r;
    cmin_nxt    = cmin_r;
    elapsed_nxt = elapsed_r;
    link_nxt    = link_r;
    done        = 1'b0;
    bad         = 1'b0;

    if (cmd == CMD_TICK) begin
      if (elapsed_r != ELAPSED_MAX) begin
        elapsed_nxt = elapsed_r + ELAPSED_W'(1);
      end
    end else if (pos_r == POS_CHECK) begin
      done    = 1'b1;
      pos_nxt = POS_HUNT;
      if (rx_byte == xor_r) begin
        volt_nxt    = {shadow_r[0], shadow_r[1]};
        curr_nxt    = {shadow_r[2], shadow_r[3]};
        charge_nxt  = shadow_r[4];
        temp_nxt    = shadow_r[5];
        cmax_nxt    = {shadow_r[6], shadow_r[7]};
        cmin_nxt    = {shadow_r[8], shadow_r[9]};
        link_nxt    = 1'b1;
        elapsed_nxt = '0;
      end else begin
        bad = 1'b1;
      end
    end else if (pos_r == POS_HUNT) begin
      if (rx_byte == start_marker_r) begin
        pos_nxt = POS_FIRST;
        xor_nxt = '0;
      end
    end else if (pos_r <= POS_LAST) begin
      // data bytes shift in, oldest ends at entry zero
      for (int i = 0; i < DATA_BYTES - 1; i++) begin
        shadow_nxt[i] = shadow_r[i+1];
      end
      shadow_nxt[DATA_BYTES-1] = rx_byte;
      xor_nxt = xor_r ^ rx_byte;
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = POS_HUNT;
    end

    // link timeout
    if (elapsed_nxt > {1'b0, crit_timeout_r}) begin
      link_nxt = 1'b0;
    end

    res.frame_done      = done;
    res.checksum_bad    = bad;
    res.link_ok         = link_nxt;
    res.pack_voltage_cv = link_nxt ? volt_nxt : '0;
    res.pack_current_ca = link_nxt ? curr_nxt : '0;
    res.charge_percent  = link_nxt ? charge_nxt : '0;
    res.pack_temp_c     = link_nxt ? temp_nxt : '0;
    res.cell_max_mv     = link_nxt ? cmax_nxt : '0;
    res.cell_min_mv     = link_nxt ? cmin_nxt : '0;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_HUNT;
      xor_r     <= '0;
      volt_r    <= '0;
      curr_r    <= '0;
      charge_r  <= '0;
      temp_r    <= '0;
      cmax_r    <= '0;
      cmin_r    <= '0;
      elapsed_r <= '0;
      link_r    <= 1'b0;
    end else if (in_fire) begin
      pos_r     <= pos_nxt;
      xor_r     <= xor_nxt;
      volt_r    <= volt_nxt;
      curr_r    <= curr_nxt;
      charge_r  <= charge_nxt;
      temp_r    <= temp_nxt;
      cmax_r    <= cmax_nxt;
      cmin_r    <= cmin_nxt;
      elapsed_r <= elapsed_nxt;
      link_r    <= link_nxt;
    end
  end

  // frame shadow bytes, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      shadow_r <= shadow_nxt;
    end
  end

  // output buffer control
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (in_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  // output buffer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_data_r};

endmodule

// File: hdl/btfr_checker.sv
// port-level checks for the battery telemetry frame receiver, bound to the top level
module btfr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [btfr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import btfr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // bad checksum only on a finished frame
  a_bad_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("checksum_bad without frame_done");

  // good frame brings the link up
  a_good_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] && !out_tdata[1] |-> out_tdata[2])
    else $error("good frame without link_ok");

  // link down hides all data fields
  a_link_down_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[OUT_TDATA_W-1:3] == '0)
    else $error("data fields nonzero while link down");

endmodule

bind battery_telemetry_frame_receiver btfr_checker u_btfr_checker (.*);

// File: tb/battery_telemetry_frame_receiver_test.sv
// self-checking testbench for the battery telemetry frame receiver
module battery_telemetry_frame_receiver_test;
  import btfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 225;
  localparam int DRAIN_CYCLES = 4;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT   = 2'd0,
    CHK_QUIET     = 2'd1,
    CHK_GOOD_ONES = 2'd2,
    CHK_BAD_ONES  = 2'd3
  } row_check_t;

  typedef struct packed {
    btfr_cmd_t  cmd;
    logic [7:0] rx_byte;
    row_check_t how;
  } probe_t;

  // directed items at reset settings: good all-ones frame, then a bad frame
  // carrying the marker, a tick and extreme bytes
  localparam int N_DIRECTED = 26;
  localparam probe_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{CMD_BYTE, 8'h00, CHK_QUIET},
    '{CMD_BYTE, 8'hAA, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'hFF, CHK_QUIET},
    '{CMD_BYTE, 8'h00, CHK_GOOD_ONES},
    '{CMD_BYTE, 8'hAA, CHK_PREDICT},
    '{CMD_BYTE, 8'h00, CHK_PREDICT},
    '{CMD_BYTE, 8'hAA, CHK_PREDICT},
    '{CMD_TICK, 8'h5A, CHK_PREDICT},
    '{CMD_BYTE, 8'h80, CHK_PREDICT},
    '{CMD_BYTE, 8'h7F, CHK_PREDICT},
    '{CMD_BYTE, 8'h01, CHK_PREDICT},
    '{CMD_BYTE, 8'hFE, CHK_PREDICT},
    '{CMD_BYTE, 8'h12, CHK_PREDICT},
    '{CMD_BYTE, 8'h34, CHK_PREDICT},
    '{CMD_BYTE, 8'h56, CHK_PREDICT},
    '{CMD_BYTE, 8'hFF, CHK_PREDICT},
    '{CMD_BYTE, 8'h24, CHK_BAD_ONES}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // [7:0] rx_byte
  logic [0:0]            in_tuser;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] frame_done, [1] checksum_bad, [2] link_ok, [18:3] pack_voltage_cv,
  // [34:19] pack_current_ca, [42:35] charge_percent, [50:43] pack_temp_c,
  // [66:51] cell_max_mv, [82:67] cell_min_mv, upper bits zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // receiver state mirror
  logic [7:0]           marker_reg;
  logic [15:0]          timeout_reg;
  logic [POS_W-1:0]     frame_pos;
  logic [7:0]           frame_xor;
  logic [7:0]           frame_bytes [DATA_BYTES];
  logic [15:0]          held_voltage, held_current, held_cell_max, held_cell_min;
  logic [7:0]           held_charge, held_temp;
  logic [ELAPSED_W-1:0] ms_since_frame;
  logic                 link_up;

  btfr_result_t telemetry_due [$];

  int errors, items_sent, results_seen, cycle_count;
  int frames_good, frames_bad, link_drops;
  int send_idle_pct, recv_idle_pct;

  battery_telemetry_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // advance the mirror by one item and return the telemetry it should show
  function automatic btfr_result_t telemetry_after(btfr_cmd_t cmd, logic [7:0] b);
    btfr_result_t r;
    logic         was_up;
    r      = '0;
    was_up = link_up;
    if (cmd == CMD_TICK) begin
      if (ms_since_frame != ELAPSED_MAX) ms_since_frame = ms_since_frame + 1'b1;
    end else if (frame_pos == POS_CHECK) begin
      r.frame_done = 1'b1;
      if (b == frame_xor) begin
        held_voltage   = {frame_bytes[0], frame_bytes[1]};
        held_current   = {frame_bytes[2], frame_bytes[3]};
        held_charge    = frame_bytes[4];
        held_temp      = frame_bytes[5];
        held_cell_max  = {frame_bytes[6], frame_bytes[7]};
        held_cell_min  = {frame_bytes[8], frame_bytes[9]};
        link_up        = 1'b1;
        ms_since_frame = '0;
        frames_good++;
      end else begin
        r.checksum_bad = 1'b1;
        frames_bad++;
      end
      frame_pos = POS_HUNT;
    end else if (frame_pos == POS_HUNT) begin
      if (b == marker_reg) begin
        frame_pos = POS_FIRST;
        frame_xor = '0;
      end
    end else if (frame_pos <= POS_LAST) begin
      frame_bytes[frame_pos - POS_FIRST] = b;
      frame_xor = frame_xor ^ b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      frame_pos = POS_HUNT;
    end
    // timeout applies after every item
    if (ms_since_frame > {1'b0, timeout_reg}) link_up = 1'b0;
    if (was_up && !link_up) link_drops++;
    r.link_ok = link_up;
    if (link_up) begin
      r.pack_voltage_cv = held_voltage;
      r.pack_current_ca = held_current;
      r.charge_percent  = held_charge;
      r.pack_temp_c     = held_temp;
      r.cell_max_mv     = held_cell_max;
      r.cell_min_mv     = held_cell_min;
    end
    return r;
  endfunction

  // offer one item, with random sender gaps, and queue its telemetry
  task automatic send_item(input btfr_cmd_t cmd, input logic [7:0] b, input row_check_t how);
    btfr_result_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= cmd;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    due = telemetry_after(cmd, b);
    case (how)
      CHK_QUIET: due = '0;
      CHK_GOOD_ONES: begin
        due = '1;
        due.checksum_bad = 1'b0;
      end
      CHK_BAD_ONES: due = '1;
      default: ;
    endcase
    telemetry_due.push_back(due);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering items and let every pending result come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (telemetry_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_START_MARKER) marker_reg = data[7:0];
    else timeout_reg = data;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver backpressure
  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    btfr_result_t got, want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, telemetry_due.size());
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = btfr_result_t'(out_tdata[RES_W-1:0]);
      if (telemetry_due.size() == 0) begin
        $display("%0t: result with no item pending, expected none got %h", $time, got);
        errors++;
      end else begin
        want = telemetry_due.pop_front();
        results_seen++;
        check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        check_field("checksum_bad", 16'(want.checksum_bad), 16'(got.checksum_bad));
        check_field("link_ok", 16'(want.link_ok), 16'(got.link_ok));
        check_field("pack_voltage_cv", want.pack_voltage_cv, got.pack_voltage_cv);
        check_field("pack_current_ca", want.pack_current_ca, got.pack_current_ca);
        check_field("charge_percent", 16'(want.charge_percent), 16'(got.charge_percent));
        check_field("pack_temp_c", 16'(want.pack_temp_c), 16'(got.pack_temp_c));
        check_field("cell_max_mv", want.cell_max_mv, got.cell_max_mv);
        check_field("cell_min_mv", want.cell_min_mv, got.cell_min_mv);
        check_field("padding", '0, 16'(out_tdata[OUT_TDATA_W-1:RES_W]));
      end
    end
  end

  initial begin
    int         pick, phase_goal, burst;
    logic [7:0] new_marker, b;
    logic [15:0] new_timeout;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    errors = 0; items_sent = 0; results_seen = 0; cycle_count = 0;
    frames_good = 0; frames_bad = 0; link_drops = 0;
    send_idle_pct = 24;
    recv_idle_pct = 64;

    // mirror starts at reset values
    marker_reg     = START_MARKER_RST;
    timeout_reg    = CRIT_TIMEOUT_RST;
    frame_pos      = POS_HUNT;
    frame_xor      = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    held_voltage   = '0;
    held_current   = '0;
    held_charge    = '0;
    held_temp      = '0;
    held_cell_max  = '0;
    held_cell_min  = '0;
    ms_since_frame = '0;
    link_up        = 1'b0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].how);

    // random part, two settings per idling regime
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 24; recv_idle_pct = 64; end
        1: begin send_idle_pct = 64; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      drain();
      case (ph)
        0: begin new_marker = 8'h00; new_timeout = 16'd0; end
        1: begin new_marker = 8'hFF; new_timeout = 16'hFFFF; end
        2: begin new_marker = 8'($urandom); new_timeout = 16'($urandom_range(1, 30)); end
        3: begin new_marker = 8'hAA; new_timeout = 16'd3; end
        4: begin new_marker = 8'($urandom); new_timeout = 16'($urandom_range(0, 60)); end
        default: begin new_marker = 8'h3C; new_timeout = 16'd12; end
      endcase
      write_reg(REG_START_MARKER, {8'h00, new_marker});
      write_reg(REG_CRIT_TIMEOUT, new_timeout);

      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // frame with random content, sometimes a wrong checksum
          send_item(CMD_BYTE, marker_reg, CHK_PREDICT);
          for (int i = 0; i < DATA_BYTES; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(CMD_TICK, 8'($urandom), CHK_PREDICT);
            pick = $urandom_range(0, 99);
            if (pick < 12) b = marker_reg;
            else if (pick < 20) b = 8'h00;
            else if (pick < 28) b = 8'hFF;
            else b = 8'($urandom);
            send_item(CMD_BYTE, b, CHK_PREDICT);
          end
          b = frame_xor;
          if ($urandom_range(0, 3) == 0) b = b ^ 8'($urandom_range(1, 255));
          send_item(CMD_BYTE, b, CHK_PREDICT);
        end else if (pick < 80) begin
          // tick burst, long enough to cross a short timeout
          burst = $urandom_range(1, (timeout_reg < 16'd40) ? int'(timeout_reg) + 3 : 40);
          repeat (burst) send_item(CMD_TICK, 8'($urandom), CHK_PREDICT);
        end else begin
          // noise
          repeat ($urandom_range(1, 6))
            send_item(btfr_cmd_t'($urandom_range(0, 3) == 0), 8'($urandom), CHK_PREDICT);
        end
      end
    end

    drain();
    $display("covered %0d items and %0d results over %0d register settings",
             items_sent, results_seen, PHASES + 1);
    $display("saw %0d good frames, %0d bad checksums and %0d link losses",
             frames_good, frames_bad, link_drops);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
